### src/tq_pkg.sv
// Shared types and codes for the team queue core.
// No dependencies; used by team_queue_core.
package tq_pkg;

	localparam int OP_W     = 2;
	localparam int DATA_W   = 16;
	localparam int GID_W    = 4;
	localparam int STATUS_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_DEFINE  = 2'd0,
		OP_ENQUEUE = 2'd1,
		OP_DEQUEUE = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_GFULL   = 3'd3,
		ST_MFULL   = 3'd4
	} status_t;

endpackage

### src/tq_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; holds the per-group element storage of the team queue.
module tq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### src/team_queue_core.sv
// Team queue core: each accepted beat passes the input stage, then the result stage.
// Throughput one item per cycle; busy stays low, every cycle can take a beat.
// Each item is resolved in the input stage against the member CAM and the group/order
// registers; the element RAM read for a dequeue lands in the result cycle.
// Reset (arst_n low) empties the member table, all group FIFOs and the order ring
// at once; no clearing pass. Results cannot be held off by the receiver.
module team_queue_core #(
	parameter int GROUPS      = 16,
	parameter int MEMBERS     = 64,
	parameter int GROUP_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tq_pkg::OP_W-1:0]       opcode,
	input  logic [tq_pkg::DATA_W-1:0]     element_value,
	input  logic [tq_pkg::GID_W-1:0]      group_id,
	output logic                          done,
	output logic [tq_pkg::STATUS_W-1:0]   status,
	output logic                          data_valid,
	output logic [tq_pkg::DATA_W-1:0]     dequeued_value
);

	localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int OFW = $clog2(GROUPS + 1);
	localparam int OSW = GW + 2;
	localparam int MW  = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
	localparam int MCW = $clog2(MEMBERS + 1);
	localparam int HW  = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
	localparam int FW  = $clog2(GROUP_DEPTH + 1);
	localparam int SW  = HW + 2;
	localparam int SD  = GROUPS * GROUP_DEPTH;
	localparam int AW  = (SD > 1) ? $clog2(SD) : 1;
	localparam int NGID = 2 ** tq_pkg::GID_W;

	// input stage
	logic                        vld_s1;
	logic [tq_pkg::OP_W-1:0]     op_s1;
	logic [tq_pkg::DATA_W-1:0]   val_s1;
	logic [tq_pkg::GID_W-1:0]    gid_s1;

	// result stage
	logic                        done_s2;
	tq_pkg::status_t             status_s2;
	logic                        dvalid_s2;

	// member CAM
	logic [tq_pkg::DATA_W-1:0]   mem_val_q [MEMBERS];
	logic [GW-1:0]               mem_grp_q [MEMBERS];
	logic [MCW-1:0]              mcount_q;

	// group FIFO pointers and group order ring
	logic [HW-1:0]               ghead_q [GROUPS];
	logic [FW-1:0]               gfill_q [GROUPS];
	logic [GW-1:0]               ring_q [GROUPS];
	logic [GW-1:0]               ohead_q;
	logic [OFW-1:0]              ofill_q;

	logic [GW-1:0]               gmod_tbl [NGID];

	logic                        accept;
	logic [MEMBERS-1:0]          hit;
	logic                        found;
	logic [GW-1:0]               mgrp;
	logic [GW-1:0]               sel_g;
	logic [HW-1:0]               head_g;
	logic [FW-1:0]               fill_g;
	logic [SW-1:0]               slot_sum;
	logic [HW-1:0]               slot;
	logic [OSW-1:0]              tail_sum;
	logic [GW-1:0]               tail;
	logic [GW-1:0]               ohead_nx;
	logic [HW-1:0]               ghead_inc;

	tq_pkg::status_t             status_d;
	logic                        dvalid_d;
	logic                        upd_hit;
	logic                        upd_new;
	logic                        g_upd;
	logic [HW-1:0]               ghead_d;
	logic [FW-1:0]               gfill_d;
	logic                        ring_wr;
	logic                        oh_adv;
	logic                        of_inc;
	logic                        of_dec;
	logic                        ram_en;
	logic                        ram_we;
	logic [HW-1:0]               ram_off;
	logic [AW-1:0]               ram_addr;
	logic [tq_pkg::DATA_W-1:0]   ram_rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// group ids wrap onto the configured group count
	for (genvar gi = 0; gi < NGID; gi++) begin : g_gmod
		assign gmod_tbl[gi] = GW'(gi % GROUPS);
	end

	always_comb begin
		hit  = '0;
		mgrp = '0;
		for (int i = 0; i < MEMBERS; i++) begin
			hit[i] = (MCW'(i) < mcount_q) && (mem_val_q[i] == val_s1);
			if (hit[i]) begin
				mgrp = mgrp | mem_grp_q[i];
			end
		end
		found = |hit;
	end

	assign sel_g  = (op_s1 == tq_pkg::OP_DEQUEUE) ? ring_q[ohead_q] : mgrp;
	assign head_g = ghead_q[sel_g];
	assign fill_g = gfill_q[sel_g];

	assign slot_sum = SW'(head_g) + SW'(fill_g);
	assign slot = (slot_sum >= SW'(GROUP_DEPTH)) ? HW'(slot_sum - SW'(GROUP_DEPTH))
		: HW'(slot_sum);
	assign ghead_inc = (head_g == HW'(GROUP_DEPTH - 1)) ? '0 : head_g + 1'b1;

	assign tail_sum = OSW'(ohead_q) + OSW'(ofill_q);
	assign tail = (tail_sum >= OSW'(GROUPS)) ? GW'(tail_sum - OSW'(GROUPS)) : GW'(tail_sum);
	assign ohead_nx = (ohead_q == GW'(GROUPS - 1)) ? '0 : ohead_q + 1'b1;

	always_comb begin
		status_d = tq_pkg::ST_OK;
		dvalid_d = 1'b0;
		upd_hit  = 1'b0;
		upd_new  = 1'b0;
		g_upd    = 1'b0;
		ghead_d  = head_g;
		gfill_d  = fill_g;
		ring_wr  = 1'b0;
		oh_adv   = 1'b0;
		of_inc   = 1'b0;
		of_dec   = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_off  = head_g;
		if (vld_s1) begin
			case (op_s1)
				tq_pkg::OP_DEFINE: begin
					if (found) begin
						upd_hit = 1'b1;
					end else if (mcount_q >= MCW'(MEMBERS)) begin
						status_d = tq_pkg::ST_MFULL;
					end else begin
						upd_new = 1'b1;
					end
				end
				tq_pkg::OP_ENQUEUE: begin
					if (!found) begin
						status_d = tq_pkg::ST_UNKNOWN;
					end else if (fill_g >= FW'(GROUP_DEPTH)) begin
						status_d = tq_pkg::ST_GFULL;
					end else begin
						ram_en  = 1'b1;
						ram_we  = 1'b1;
						ram_off = slot;
						g_upd   = 1'b1;
						gfill_d = fill_g + 1'b1;
						if (fill_g == '0 && ofill_q < OFW'(GROUPS)) begin
							ring_wr = 1'b1;
							of_inc  = 1'b1;
						end
					end
				end
				tq_pkg::OP_DEQUEUE: begin
					if (ofill_q == '0) begin
						status_d = tq_pkg::ST_EMPTY;
					end else if (fill_g == '0) begin
						// stale ring entry: drop it
						status_d = tq_pkg::ST_EMPTY;
						oh_adv   = 1'b1;
						of_dec   = 1'b1;
					end else begin
						ram_en   = 1'b1;
						dvalid_d = 1'b1;
						g_upd    = 1'b1;
						ghead_d  = ghead_inc;
						gfill_d  = fill_g - 1'b1;
						if (fill_g == FW'(1)) begin
							oh_adv = 1'b1;
							of_dec = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign ram_addr = AW'(sel_g) * AW'(GROUP_DEPTH) + AW'(ram_off);

	tq_ram #(
		.WIDTH (tq_pkg::DATA_W),
		.DEPTH (SD)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (val_s1),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			done_s2  <= 1'b0;
			mcount_q <= '0;
			ohead_q  <= '0;
			ofill_q  <= '0;
			for (int g = 0; g < GROUPS; g++) begin
				ghead_q[g] <= '0;
				gfill_q[g] <= '0;
			end
		end else begin
			vld_s1  <= accept;
			done_s2 <= vld_s1;
			if (upd_new) begin
				mcount_q <= mcount_q + 1'b1;
			end
			if (g_upd) begin
				ghead_q[sel_g] <= ghead_d;
				gfill_q[sel_g] <= gfill_d;
			end
			if (oh_adv) begin
				ohead_q <= ohead_nx;
			end
			if (of_inc) begin
				ofill_q <= ofill_q + 1'b1;
			end else if (of_dec) begin
				ofill_q <= ofill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= opcode;
			val_s1 <= element_value;
			gid_s1 <= group_id;
		end
		for (int i = 0; i < MEMBERS; i++) begin
			if (upd_hit && hit[i]) begin
				mem_grp_q[i] <= gmod_tbl[gid_s1];
			end
		end
		if (upd_new) begin
			mem_val_q[mcount_q[MW-1:0]] <= val_s1;
			mem_grp_q[mcount_q[MW-1:0]] <= gmod_tbl[gid_s1];
		end
		if (ring_wr) begin
			ring_q[tail] <= sel_g;
		end
		status_s2 <= status_d;
		dvalid_s2 <= dvalid_d;
	end

	assign done           = done_s2;
	assign status         = status_s2;
	assign data_valid     = dvalid_s2;
	assign dequeued_value = dvalid_s2 ? ram_rdata : '0;

	// every accepted beat yields exactly one result beat through the input and result stages
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result beat missing after accept");

	a_pop_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && data_valid) |-> (status == tq_pkg::ST_OK))
		else $error("popped element with non-ok status");

	// the ring only holds non-empty groups, so a non-empty ring always pops
	a_ring_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && op_s1 == tq_pkg::OP_DEQUEUE && ofill_q != '0) |=> data_valid)
		else $error("dequeue on non-empty ring gave no element");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(ofill_q <= OFW'(GROUPS)) && (mcount_q <= MCW'(MEMBERS)))
		else $error("order or member count overflow");

endmodule
